FILE: rtl/core/salid_pkg.sv
// ----------------------------------------------------------------------------
// salid_pkg
// Shared types and constants for the sorted list with insert and delete.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package salid_pkg;

	// Default number of cells in the chain
	localparam int CAPACITY_DEF = 16;

	// Fixed field widths
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;

	// Width of a count for the default capacity
	localparam int COUNT_W_DEF = $clog2(CAPACITY_DEF + 1);

	// Operation codes on the func field
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_DELETE = 1'b1;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		STATUS_DONE      = 2'd0,
		STATUS_NOT_FOUND = 2'd1,
		STATUS_FULL      = 2'd2
	} status_t;

	// Command broadcast from the control to every cell
	typedef struct packed {
		logic                      ins_en;
		logic                      del_en;
		logic signed [VALUE_W-1:0] value;
	} cell_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/salid_req_if.sv
// ----------------------------------------------------------------------------
// salid_req_if
// Request channel: one insert or delete operation per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface salid_req_if
	import salid_pkg::*;
	();

	logic                      valid;
	logic                      ready;
	logic                      func;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output func, output value, input ready);
	modport sink   (input valid, input func, input value, output ready);

endinterface

`default_nettype wire

FILE: rtl/core/salid_rsp_if.sv
// ----------------------------------------------------------------------------
// salid_rsp_if
// Response channel: shift count, status and new count per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface salid_rsp_if
	import salid_pkg::*;
	#(
	parameter int COUNT_W = COUNT_W_DEF
	) ();

	logic                valid;
	logic                ready;
	logic [COUNT_W-1:0]  moves;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  new_count;

	modport source (output valid, output moves, output status, output new_count,
		input ready);
	modport sink   (input valid, input moves, input status, input new_count,
		output ready);

endinterface

`default_nettype wire

FILE: rtl/core/salid_cell.sv
// ----------------------------------------------------------------------------
// salid_cell
// One list entry: compares against the broadcast value and shifts in from
// its left neighbour on insert or from its right neighbour on delete.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module salid_cell
	import salid_pkg::*;
	(
	input  wire logic                      clk,
	input  wire cell_cmd_t                 cmd,
	input  wire logic                      occupied,
	input  wire logic                      left_less,
	input  wire logic signed [VALUE_W-1:0] left_entry,
	input  wire logic signed [VALUE_W-1:0] right_entry,
	output logic                           less,
	output logic                           boundary,
	output logic                           equal,
	output logic signed [VALUE_W-1:0]      entry
	);

	logic signed [VALUE_W-1:0] entry_q;

	// Compare against the broadcast value; empty cells never count as less
	always_comb begin
		less     = occupied && (entry_q < cmd.value);
		equal    = occupied && (entry_q == cmd.value);
		boundary = left_less && !less;
	end

	assign entry = entry_q;

	// Shift: right of the boundary on insert, at or after the match on delete
	always_ff @(posedge clk) begin
		if (cmd.ins_en) begin
			if (!left_less) begin
				entry_q <= left_entry;
			end else if (!less) begin
				entry_q <= cmd.value;
			end
		end else if (cmd.del_en && occupied && !less) begin
			entry_q <= right_entry;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/salid_pos_enc.sv
// ----------------------------------------------------------------------------
// salid_pos_enc
// One-hot to binary encoder for the insert or match position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module salid_pos_enc #(
	parameter int N = 16
	) (
	input  wire logic [N-1:0]         onehot,
	output logic [$clog2(N)-1:0]      index
	);

	localparam int IW = $clog2(N);

	// OR together the indices of the set bits; at most one is set
	always_comb begin
		index = '0;
		for (int i = 0; i < N; i++) begin
			if (onehot[i]) begin
				index = index | IW'(i);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/sorted_array_list_insert_delete_top.sv
// ----------------------------------------------------------------------------
// sorted_array_list_insert_delete_top
// Ascending list of signed values with insert and delete of one value.
// ----------------------------------------------------------------------------
// The list lives in a chain of CAPACITY cells, one entry per cell, together
// with a count of the entries in use. Every request is compared against all
// cells at once: an insert lands at the first entry not less than the value
// and the later entries move up one cell; a delete removes the first equal
// entry and the later entries move down. One request is taken per clock and
// its response appears on rsp in the cycle after the transfer, from an output
// register, so back-to-back requests run at one per cycle while rsp is
// taken; the cycle is set by the cell compare and the position encoder.
// No clearing pass is needed after reset: only the count is cleared.
// COUNT_W of the rsp interface must equal $clog2(CAPACITY + 1).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_array_list_insert_delete_top
	import salid_pkg::*;
	#(
	parameter int CAPACITY = CAPACITY_DEF
	) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	salid_req_if.sink   req,
	salid_rsp_if.source rsp
	);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0] count_q;
	logic          rsp_valid_q;
	logic [CW-1:0] moves_q;
	status_t       status_q;
	logic [CW-1:0] new_count_q;

	logic                      take;
	logic                      full;
	logic                      found;
	logic [IW-1:0]             pos;
	cell_cmd_t                 cmd;
	logic [CW-1:0]             moves_d;
	status_t                   status_d;
	logic [CW-1:0]             count_d;

	logic [CAPACITY-1:0]       less;
	logic [CAPACITY-1:0]       boundary;
	logic [CAPACITY-1:0]       equal;
	logic signed [VALUE_W-1:0] entry [CAPACITY];

	// Accept whenever the response register is free or being emptied
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign take      = req.valid && req.ready;
	assign full      = (count_q == CW'(CAPACITY));
	assign found     = |(boundary & equal);

	// Broadcast command to the chain
	always_comb begin
		cmd.value  = req.value;
		cmd.ins_en = take && (req.func == FUNC_INSERT) && !full;
		cmd.del_en = take && (req.func == FUNC_DELETE) && found;
	end

	// Chain of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                      occ;
		logic                      l_less;
		logic signed [VALUE_W-1:0] l_entry;
		logic signed [VALUE_W-1:0] r_entry;

		assign occ = (CW'(i) < count_q);

		if (i == 0) begin : g_head
			assign l_less  = 1'b1;
			assign l_entry = req.value;
		end else begin : g_body
			assign l_less  = less[i-1];
			assign l_entry = entry[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign r_entry = entry[i];
		end else begin : g_mid
			assign r_entry = entry[i+1];
		end

		salid_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.occupied    (occ),
			.left_less   (l_less),
			.left_entry  (l_entry),
			.right_entry (r_entry),
			.less        (less[i]),
			.boundary    (boundary[i]),
			.equal       (equal[i]),
			.entry       (entry[i])
		);
	end

	// Lower-bound position: also the first match on delete
	salid_pos_enc #(
		.N (CAPACITY)
	) u_pos_enc (
		.onehot (boundary),
		.index  (pos)
	);

	// Result of the operation
	always_comb begin
		moves_d  = '0;
		status_d = STATUS_DONE;
		count_d  = count_q;
		if (req.func == FUNC_INSERT) begin
			if (full) begin
				status_d = STATUS_FULL;
			end else begin
				moves_d = count_q - CW'(pos);
				count_d = count_q + CW'(1);
			end
		end else begin
			if (found) begin
				moves_d = count_q - CW'(pos) - CW'(1);
				count_d = count_q - CW'(1);
			end else begin
				status_d = STATUS_NOT_FOUND;
				moves_d  = count_q;
			end
		end
	end

	// Count and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (take) begin
			moves_q     <= moves_d;
			status_q    <= status_d;
			new_count_q <= count_d;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.moves     = moves_q;
	assign rsp.status    = status_q;
	assign rsp.new_count = new_count_q;

endmodule

`default_nettype wire

FILE: rtl/core/salid_checker.sv
// ----------------------------------------------------------------------------
// salid_checker
// Port-level checks on the sorted list, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module salid_checker
	import salid_pkg::*;
	#(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int CW       = $clog2(CAPACITY + 1)
	) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                req_valid,
	input wire logic                req_ready,
	input wire logic                rsp_valid,
	input wire logic                rsp_ready,
	input wire logic [CW-1:0]       moves,
	input wire logic [STATUS_W-1:0] status,
	input wire logic [CW-1:0]       new_count
	);

	// A stalled response holds its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(moves) && $stable(status)
		&& $stable(new_count))
		else $error("response changed while stalled");

	// Every request transfer yields a response in the next cycle
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("no response after request transfer");

	// Count never exceeds capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> new_count <= CW'(CAPACITY))
		else $error("count above capacity");

	// A full list reports no shifts and a full count
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == STATUS_FULL) |-> (moves == '0)
		&& (new_count == CW'(CAPACITY)))
		else $error("full response inconsistent");

	// A missed delete reports the count as its shift count
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == STATUS_NOT_FOUND) |-> moves == new_count)
		else $error("miss response inconsistent");

endmodule

bind sorted_array_list_insert_delete_top salid_checker #(
	.CAPACITY (CAPACITY)
) u_salid_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.moves     (rsp.moves),
	.status    (rsp.status),
	.new_count (rsp.new_count)
);

`default_nettype wire
